FILE: hw/rtl/windowed_counter_rate_meter_assert.svh
// Assertion macros for the windowed counter rate meter.
`ifndef WINDOWED_COUNTER_RATE_METER_ASSERT_SVH
`define WINDOWED_COUNTER_RATE_METER_ASSERT_SVH
`ifndef SYNTHESIS
`define WCRM_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("wcrm check failed");
`define WCRM_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("wcrm check failed");
`else
`define WCRM_ASSERT_IMP(label, clk, rstn, ante, cons)
`define WCRM_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: hw/rtl/wcrm_pkg.sv
// Package: constants, types and helpers for the windowed counter rate meter.
package wcrm_pkg;
  localparam int unsigned HistoryDepthDef = 512;
  localparam int unsigned ValueW = 64;
  localparam int unsigned TimeW = 32;
  localparam int unsigned RateW = 56;
  localparam int unsigned HeldW = 10;
  localparam int unsigned NumWin = 3;
  localparam logic [TimeW-1:0] SlackMs = 32'd500;
  localparam logic [TimeW-1:0] MinSpanMs = 32'd100;
  localparam logic [RateW-1:0] RateMax = {RateW{1'b1}};
  localparam logic [31:0] WinShortRst = 32'd10000;
  localparam logic [31:0] WinMidRst = 32'd60000;
  localparam logic [31:0] WinLongRst = 32'd300000;
  localparam logic [1:0] RegShort = 2'd0;
  localparam logic [1:0] RegMid = 2'd1;
  localparam logic [1:0] RegLong = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WRITE, ST_NEWEST_RD, ST_NEWEST_WAIT, ST_WALK_RD, ST_WALK_WAIT,
    ST_WALK_CHK, ST_DIV_START, ST_DIV_WAIT, ST_NEXT_WIN, ST_OUT
  } wcrm_state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;
endpackage

FILE: hw/rtl/wcrm_if.sv
// Valid/ready channel interface with source and sink views.
interface wcrm_if #(parameter int unsigned W = 8) ();
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/windowed_counter_rate_meter.sv
// Top level of the windowed counter rate meter.
// Windowed counter rate meter. Each accepted item (a 64-bit cumulative counter
// reading and a 32-bit ms timestamp) is written into a ring of HISTORY_DEPTH
// readings. Then, for each of the three windows (APB registers 0..2 at byte
// addresses 0, 4, 8), the ring is walked from the newest reading back to the
// first whose age is at least window - 500 ms, else the oldest held. The rate
// is rise*256000/span (Q48.8 counts per second), truncated, saturated to
// 2^56-1, and 0 when the span is under 100 ms or the counter did not rise.
// Work per item: the item is written, the newest reading is read back, then
// for each window the ring is walked (1..valid count readings) and the rate
// is divided; a window whose rate is 0 by rule skips the divider. The walk
// reads one ring entry at a time through a single RAM port and the rate
// comes from one serial divider shared by all windows. The input is not
// ready while an item is in work; the result sits in its own output
// register until taken, so the next item can be worked on meanwhile, and
// only a second finished result waits for it.
// No clearing pass: only written entries are read.
module windowed_counter_rate_meter #(
  parameter int unsigned HISTORY_DEPTH = wcrm_pkg::HistoryDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  wcrm_if.sink        in_ch,
  wcrm_if.source      out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import wcrm_pkg::*;
  `include "windowed_counter_rate_meter_assert.svh"

  localparam int unsigned PtrW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CntW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(HISTORY_DEPTH);

  // configuration
  logic [31:0] win_r [NumWin];
  logic [1:0]  cfg_idx;
  assign cfg_pready = 1'b1;
  assign cfg_idx = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r[0] <= WinShortRst;
      win_r[1] <= WinMidRst;
      win_r[2] <= WinLongRst;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_idx)
        RegShort: win_r[0] <= cfg_pwdata;
        RegMid:   win_r[1] <= cfg_pwdata;
        RegLong:  win_r[2] <= cfg_pwdata;
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegShort: cfg_prdata = win_r[0];
      RegMid:   cfg_prdata = win_r[1];
      RegLong:  cfg_prdata = win_r[2];
      default:  cfg_prdata = '0;
    endcase
  end

  // state
  wcrm_state_t      st_r, st_nxt;
  logic [PtrW-1:0]  wp_r, wp_nxt;
  logic [CntW-1:0]  vc_r, vc_nxt;
  logic [CntW-1:0]  back_r, back_nxt;
  logic [1:0]       win_sel_r, win_sel_nxt;
  logic [ValueW-1:0] in_val_r, new_val_r;
  logic [TimeW-1:0]  in_time_r, new_time_r;
  logic [RateW-1:0]  rate_r [NumWin];
  logic [RateW-1:0]  out_rate_r [NumWin];
  logic              out_valid_r;
  logic              out_load;
  logic [HeldW-1:0]  held_r;

  // ring memories
  logic              ram_we;
  logic [PtrW-1:0]   ram_addr;
  logic [ValueW-1:0] ram_vq;
  logic [TimeW-1:0]  ram_tq;

  wcrm_ram #(.WIDTH(ValueW), .DEPTH(HISTORY_DEPTH)) u_vring (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(in_val_r), .rdata(ram_vq));
  wcrm_ram #(.WIDTH(TimeW), .DEPTH(HISTORY_DEPTH)) u_tring (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(in_time_r), .rdata(ram_tq));

  // slot 'back' places before the write pointer (pointer already advanced)
  logic [PtrW:0] slot_wide;
  assign slot_wide = {1'b0, wp_r} + (PtrW+1)'(HISTORY_DEPTH) - (PtrW+1)'(back_r);

  always_comb begin
    if (slot_wide >= (PtrW+1)'(HISTORY_DEPTH)) begin
      ram_addr = PtrW'(slot_wide - (PtrW+1)'(HISTORY_DEPTH));
    end else begin
      ram_addr = slot_wide[PtrW-1:0];
    end
    if (st_r == ST_WRITE) begin
      ram_addr = wp_r;
    end
  end

  // candidate qualification: age >= window - 500, signed compare
  logic [TimeW-1:0] age;
  logic [32:0]      thresh;
  logic             qualifies;
  logic [31:0]      cur_win;
  assign cur_win = win_r[win_sel_r];
  assign age = new_time_r - ram_tq;
  assign thresh = {1'b0, cur_win} - {1'b0, SlackMs};
  assign qualifies = thresh[32] || ({1'b0, age} >= thresh);

  // picked reading
  logic [ValueW-1:0] rise_r;
  logic [TimeW-1:0]  span_r;
  logic              zero_r;

  // rate = floor(rise * 256000 / span), exact; rise * 256000 = (rise * 125) << 11
  logic [70:0] rise_x125;
  logic [81:0] div_in;
  assign rise_x125 = {rise_r, 7'd0} - {6'd0, rise_r, 1'b0} - {7'd0, rise_r};
  assign div_in = {rise_x125, 11'd0};

  div_ctl_t   dctl;
  div_sts_t   dsts;
  logic [81:0] dquot;
  wcrm_div u_div (
    .clk(clk), .rst_n(rst_n), .ctl(dctl),
    .dividend(div_in), .divisor(span_r), .sts(dsts), .quotient(dquot));

  logic [RateW-1:0] rate_calc;
  always_comb begin
    if (zero_r) begin
      rate_calc = '0;
    end else if (dquot[81:RateW] != '0) begin
      rate_calc = RateMax;
    end else begin
      rate_calc = dquot[RateW-1:0];
    end
  end

  assign out_load = (st_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:        if (in_ch.valid && in_ch.ready) st_nxt = ST_WRITE;
      ST_WRITE:       st_nxt = ST_NEWEST_RD;
      ST_NEWEST_RD:   st_nxt = ST_NEWEST_WAIT;
      ST_NEWEST_WAIT: st_nxt = ST_WALK_RD;
      ST_WALK_RD:     st_nxt = ST_WALK_WAIT;
      ST_WALK_WAIT:   st_nxt = ST_WALK_CHK;
      ST_WALK_CHK:    st_nxt = (qualifies || back_r == vc_r) ? ST_DIV_START : ST_WALK_RD;
      // a rate that is 0 by rule skips the divider
      ST_DIV_START:   st_nxt = zero_r ? ST_NEXT_WIN : ST_DIV_WAIT;
      ST_DIV_WAIT:    if (dsts.done) st_nxt = ST_NEXT_WIN;
      ST_NEXT_WIN:    st_nxt = (win_sel_r == 2'd2) ? ST_OUT : ST_WALK_RD;
      ST_OUT:         if (out_load) st_nxt = ST_IDLE;
      default:        st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we = (st_r == ST_WRITE);
    dctl.start = (st_r == ST_DIV_START) && !zero_r;
    wp_nxt = wp_r;
    vc_nxt = vc_r;
    back_nxt = back_r;
    win_sel_nxt = win_sel_r;
    unique case (st_r)
      ST_WRITE: begin
        wp_nxt = (wp_r == PtrW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + PtrW'(1);
        if (vc_r != DepthC) vc_nxt = vc_r + CntW'(1);
        back_nxt = CntW'(1);
        win_sel_nxt = 2'd0;
      end
      ST_WALK_CHK: begin
        if (!(qualifies || back_r == vc_r)) back_nxt = back_r + CntW'(1);
      end
      ST_NEXT_WIN: begin
        win_sel_nxt = win_sel_r + 2'd1;
        back_nxt = CntW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      wp_r <= '0;
      vc_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      wp_r <= wp_nxt;
      vc_r <= vc_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    back_r <= back_nxt;
    win_sel_r <= win_sel_nxt;
    if (in_ch.valid && in_ch.ready) begin
      in_val_r <= in_ch.data[ValueW-1:0];
      in_time_r <= in_ch.data[ValueW+TimeW-1:ValueW];
    end
    if (st_r == ST_NEWEST_WAIT) begin
      new_val_r <= ram_vq;
      new_time_r <= ram_tq;
    end
    if (st_r == ST_WALK_CHK && (qualifies || back_r == vc_r)) begin
      rise_r <= (new_val_r >= ram_vq) ? new_val_r - ram_vq : '0;
      span_r <= age;
      zero_r <= (age < MinSpanMs) || (new_val_r <= ram_vq);
    end
    if (st_r == ST_NEXT_WIN) rate_r[win_sel_r] <= rate_calc;
    if (out_load) begin
      held_r <= HeldW'(vc_r);
      out_rate_r[0] <= rate_r[0];
      out_rate_r[1] <= rate_r[1];
      out_rate_r[2] <= rate_r[2];
    end
  end

  assign in_ch.ready = (st_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = {held_r, out_rate_r[2], out_rate_r[1], out_rate_r[0]};

  `WCRM_ASSERT_IMP(a_busy_not_ready, clk, rst_n, st_r != ST_IDLE, !in_ch.ready)
  `WCRM_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, vc_r <= DepthC)
  `WCRM_ASSERT_NXT(a_accept_writes, clk, rst_n, in_ch.valid && in_ch.ready,
    st_r == ST_WRITE)
endmodule

FILE: hw/rtl/wcrm_ram.sv
// Generic single-port RAM with registered read.
module wcrm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end
endmodule

FILE: hw/rtl/wcrm_div.sv
// Restoring bit-serial divider: 82-bit dividend over 32-bit divisor.
module wcrm_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wcrm_pkg::div_ctl_t   ctl,
  input  logic [81:0]          dividend,
  input  logic [31:0]          divisor,
  output wcrm_pkg::div_sts_t   sts,
  output logic [81:0]          quotient
);
  import wcrm_pkg::*;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [81:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [32:0] shl;

  always_comb begin
    shl = {rem_r[31:0], q_r[81]};
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    q_nxt = q_r;
    rem_nxt = rem_r;
    if (ctl.start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = 7'd82;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shl >= {1'b0, divisor}) begin
        rem_nxt = shl - {1'b0, divisor};
        q_nxt = {q_r[80:0], 1'b1};
      end else begin
        rem_nxt = shl;
        q_nxt = {q_r[80:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = q_r;
endmodule

FILE: bench/windowed_counter_rate_meter_test.sv
// Testbench for the windowed counter rate meter: directed table, then random items.
`timescale 1ns / 100ps

module windowed_counter_rate_meter_test;
  import wcrm_pkg::*;

  localparam int unsigned Depth = HistoryDepthDef;
  localparam int unsigned InW = ValueW + TimeW;
  localparam int unsigned OutW = 3 * RateW + HeldW;
  localparam int unsigned StallLimit = 40000;   // far above a full-ring item plus the long hold
  localparam int unsigned LongHold = 3000;
  localparam logic [63:0] ScaleQ8 = 64'd256000;

  typedef struct packed {
    logic [HeldW-1:0] held;
    logic [RateW-1:0] rate_long;
    logic [RateW-1:0] rate_mid;
    logic [RateW-1:0] rate_short;
  } rates_t;

  typedef struct {
    logic [ValueW-1:0] value;
    logic [TimeW-1:0]  stamp;
    bit                typed;   // expectation written in the row
    rates_t            want;
  } sample_row_t;

  logic clk;
  logic rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  wcrm_if #(.W(InW))  in_if ();
  wcrm_if #(.W(OutW)) out_if ();

  windowed_counter_rate_meter dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the ring and the window registers.
  // ---------------------------------------------------------------------------
  logic [ValueW-1:0] hist_value [Depth];
  logic [TimeW-1:0]  hist_stamp [Depth];
  int unsigned       next_slot;
  int unsigned       held_count;
  logic [31:0]       window_len [NumWin];

  sample_row_t offered_q [$];    // items put on the input, not yet accepted
  rates_t      rates_due_q [$];  // expected results in order
  int unsigned errors;
  int unsigned idle_cycles;
  bit          hold_out;         // asks the receiver for one long hold-off

  // Counter rise over span, scaled to counts per second in Q48.8.
  function automatic logic [RateW-1:0] rate_q8(logic [63:0] rise, logic [31:0] span);
    logic [63:0] quo, rem, hi, lo;
    if (span < MinSpanMs || rise == 64'd0) return '0;
    quo = rise / span;
    rem = rise % span;
    if (quo > {8'd0, RateMax} / ScaleQ8) return RateMax;
    hi = quo * ScaleQ8;
    lo = (rem * ScaleQ8) / span;
    if (hi + lo > {8'd0, RateMax}) return RateMax;
    return hi[RateW-1:0] + lo[RateW-1:0];
  endfunction

  function automatic int unsigned slot_ago(int unsigned back);
    return (next_slot + Depth - back) % Depth;
  endfunction

  // Walk back from the newest sample to the first one old enough for the window.
  function automatic logic [RateW-1:0] window_rate(logic [31:0] win);
    int unsigned newest, pick, s;
    logic [31:0] age;
    longint threshold;
    logic [63:0] rise;
    newest = slot_ago(1);
    pick = slot_ago(held_count);
    threshold = longint'(win) - longint'(SlackMs);
    for (int unsigned i = 1; i <= held_count; i++) begin
      s = slot_ago(i);
      age = hist_stamp[newest] - hist_stamp[s];
      if (longint'(age) >= threshold) begin
        pick = s;
        break;
      end
    end
    age = hist_stamp[newest] - hist_stamp[pick];
    rise = (hist_value[newest] >= hist_value[pick]) ? hist_value[newest] - hist_value[pick] : '0;
    return rate_q8(rise, age);
  endfunction

  function automatic rates_t take_sample(logic [ValueW-1:0] v, logic [TimeW-1:0] t);
    rates_t r;
    hist_value[next_slot] = v;
    hist_stamp[next_slot] = t;
    next_slot = (next_slot + 1) % Depth;
    if (held_count < Depth) held_count++;
    r.rate_short = window_rate(window_len[0]);
    r.rate_mid   = window_rate(window_len[1]);
    r.rate_long  = window_rate(window_len[2]);
    r.held       = held_count[HeldW-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every accepted item, checks every accepted result.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sample_row_t row;
    rates_t got, want, calc;
    bit moved;
    if (rst_n) begin
      moved = cfg_psel && cfg_penable && cfg_pready;
      if (in_if.valid && in_if.ready) begin
        moved = 1'b1;
        if (offered_q.size() == 0) begin
          $display("%0t: input accepted with nothing offered", $time);
          errors++;
        end else begin
          row = offered_q.pop_front();
          calc = take_sample(row.value, row.stamp);
          rates_due_q.push_back(row.typed ? row.want : calc);
        end
      end
      if (out_if.valid && out_if.ready) begin
        moved = 1'b1;
        got = out_if.data;
        if (rates_due_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = rates_due_q.pop_front();
          if (got.rate_short !== want.rate_short) begin
            $display("%0t: rate_short expected %h got %h", $time, want.rate_short, got.rate_short);
            errors++;
          end
          if (got.rate_mid !== want.rate_mid) begin
            $display("%0t: rate_mid expected %h got %h", $time, want.rate_mid, got.rate_mid);
            errors++;
          end
          if (got.rate_long !== want.rate_long) begin
            $display("%0t: rate_long expected %h got %h", $time, want.rate_long, got.rate_long);
            errors++;
          end
          if (got.held !== want.held) begin
            $display("%0t: samples_held expected %0d got %0d", $time, want.held, got.held);
            errors++;
          end
        end
      end
      if (moved) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= StallLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random ready gaps, one long hold when asked.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned gap;
    out_if.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_out) begin
        gap = LongHold;
        hold_out = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 18);
      end
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and register access
  // ---------------------------------------------------------------------------
  logic [ValueW-1:0] last_value;
  logic [TimeW-1:0]  last_stamp;
  bit                burst;    // stretch with no idling on the sender

  task automatic offer(sample_row_t row);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.data  <= {row.stamp, row.value};
    in_if.valid <= 1'b1;
    offered_q.push_back(row);
    last_value = row.value;
    last_stamp = row.stamp;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
  endtask

  task automatic offer_plain(logic [ValueW-1:0] v, logic [TimeW-1:0] t);
    sample_row_t row;
    row.value = v;
    row.stamp = t;
    row.typed = 1'b0;
    row.want = '0;
    offer(row);
  endtask

  // Mostly steady once-a-second samples; the rest are bursts, jumps, clock
  // steps backwards, counter drops and wild values.
  task automatic offer_random(int unsigned count);
    logic [ValueW-1:0] v;
    logic [TimeW-1:0]  t;
    int unsigned kind;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 60 == 0) burst = ($urandom_range(0, 2) == 0);
      kind = $urandom_range(0, 99);
      v = last_value + $urandom_range(0, 100000);
      t = last_stamp + $urandom_range(900, 1100);
      if (kind >= 75 && kind < 83) t = last_stamp + $urandom_range(0, 150);
      else if (kind < 87 && kind >= 83) t = last_stamp + $urandom;
      else if (kind < 91 && kind >= 87) t = last_stamp - $urandom_range(1, 5000);
      else if (kind < 95 && kind >= 91) v = last_value - $urandom_range(1, 1000);
      else if (kind >= 95) v = {$urandom, $urandom};
      offer_plain(v, t);
    end
    burst = 1'b0;
  endtask

  task automatic settle;
    in_if.valid <= 1'b0;
    while (offered_q.size() != 0 || rates_due_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Write one register, read it back.
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_pwrite <= 1'b0; cfg_penable <= 1'b0;
    window_len[idx] = val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== val) begin
      $display("%0t: register %0d expected %h got %h", $time, idx, val, cfg_prdata);
      errors++;
    end
    cfg_psel <= 1'b0; cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write to the unused fourth slot: must not disturb anything.
  task automatic reg_write_unused(logic [31:0] val);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= 4'd12; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Directed rows, reset windows. Typed rows: first sample has no span; the
  // second gives exactly 1000 counts/s; the third saturates.
  sample_row_t directed [] = '{
    '{64'd0, 32'd0, 1'b1, '{10'd1, 56'd0, 56'd0, 56'd0}},
    '{64'd1000, 32'd1000, 1'b1, '{10'd2, 56'd256000, 56'd256000, 56'd256000}},
    '{64'hFFFF_FFFF_FFFF_FFFF, 32'd1100, 1'b1, '{10'd3, RateMax, RateMax, RateMax}},
    '{64'd5, 32'd1200, 1'b0, '0},                     // counter drops
    '{64'd10, 32'd500, 1'b0, '0},                     // clock steps back
    '{64'd20, 32'd599, 1'b0, '0},                     // span just under 100 ms
    '{64'd30, 32'd699, 1'b0, '0},
    '{64'd5000, 32'hFFFF_FFFF, 1'b0, '0},             // timestamp at its top
    '{64'd9000, 32'd1000, 1'b0, '0},                  // wraps past zero
    '{64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 1'b0, '0},
    '{64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
    '{64'hFFFF_FFFF_FFFF_FFFE, 32'hAAAA_AB00, 1'b0, '0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 32'hAAAA_AC00, 1'b0, '0}
  };

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    errors = 0; idle_cycles = 0; hold_out = 1'b0; burst = 1'b0;
    next_slot = 0; held_count = 0;
    window_len[0] = WinShortRst; window_len[1] = WinMidRst; window_len[2] = WinLongRst;
    last_value = '0; last_stamp = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase 1: reset windows, directed then random; one long receiver hold.
    foreach (directed[i]) offer(directed[i]);
    hold_out = 1'b1;
    offer_random(150);
    settle();

    // Phase 2: window under the slack, window at its top, a short window.
    reg_write(RegShort, 32'd0);
    reg_write(RegMid, 32'hFFFF_FFFF);
    reg_write(RegLong, 32'd1500);
    reg_write_unused(32'hFFFF_FFFF);
    offer_plain(last_value + 64'd7, last_stamp + 32'd1000);
    offer_plain(last_value - 64'd1, last_stamp + 32'd100);
    offer_plain(last_value + 64'd100, last_stamp + 32'd2500);
    offer_random(150);
    settle();

    // Phase 3: odd windows that straddle the slack.
    reg_write(RegShort, 32'd500);
    reg_write(RegMid, 32'd499);
    reg_write(RegLong, 32'd2_000_000);
    offer_random(80);
    settle();

    // Phase 4: back to the usual windows; the ring wraps in here.
    reg_write(RegShort, WinShortRst);
    reg_write(RegMid, WinMidRst);
    reg_write(RegLong, WinLongRst);
    offer_random(150);
    settle();
    repeat (200) @(posedge clk);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/wcrm_pkg.sv
hw/rtl/wcrm_if.sv
hw/rtl/wcrm_ram.sv
hw/rtl/wcrm_div.sv
hw/rtl/windowed_counter_rate_meter.sv
bench/windowed_counter_rate_meter_test.sv
